/* rtl/pcpg_pkg.sv */
// pcpg_pkg: shared types and constants of the curve point generator
// holds sequencer states, shape and register codes, cordic constants
// no dependencies
`default_nettype none

package pcpg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_RND,
    ST_SQ,
    ST_CUBE,
    ST_SUM,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    SHP_ASTROID     = 3'd0,
    SHP_CYCLOID     = 3'd1,
    SHP_HUYGENS     = 3'd2,
    SHP_HYPOCYCLOID = 3'd3,
    SHP_LINE        = 3'd4,
    SHP_CIRCLE      = 3'd5,
    SHP_ELLIPSE     = 3'd6,
    SHP_STARFISH    = 3'd7
  } shape_t;

  localparam logic [2:0] REG_SHAPE    = 3'd0;
  localparam logic [2:0] REG_SCALE    = 3'd1;
  localparam logic [2:0] REG_STEPS    = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;

  localparam int CORDIC_ITERS = 18;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [27:0] FOUR_PI_Q24 = 28'd210828715;

  // arctan(2^-i) in 32-bit turns
  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    logic signed [31:0] a;
    unique case (i)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933405;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10680862;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335086;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41721;
      5'd15:   a = 32'sd20860;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/parametric_curve_point_generator.sv */
// Curve point generator: one step index in, one pixel and the previous pixel
// out. Each point but the line runs a cordic rotation once, or twice for the
// huygens, hypocycloid and starfish curves, followed by rounding, squaring,
// cubing, summing, scaling and output in a shared datapath; the line goes
// straight to summing. The input stays closed (in_stall high) from acceptance
// until the result beat is loaded, and longer while a previous beat is still
// held by out_stall. A finished beat waits in the output register while the
// next item may be accepted.
// depends on pcpg_pkg
`default_nettype none

module parametric_curve_point_generator #(
  parameter int MAX_STEPS_LOG2 = 8,
  parameter int ANGLE_BITS     = 16,
  parameter int PIXEL_BITS     = 15
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [10:0]                  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [8:0]                   step_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [PIXEL_BITS-1:0]      pixel_x,
  output logic signed [PIXEL_BITS-1:0]      pixel_y,
  output logic signed [PIXEL_BITS-1:0]      prev_x,
  output logic signed [PIXEL_BITS-1:0]      prev_y
);

  localparam int IDXW = (MAX_STEPS_LOG2 + 1 > 9) ? MAX_STEPS_LOG2 + 1 : 9;
  localparam int KW   = IDXW + 3;
  localparam logic signed [31:0] PIX_HI = (32'sd1 <<< (PIXEL_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] PIX_LO = -(32'sd1 <<< (PIXEL_BITS - 1));

  // configuration
  logic [2:0]  shape;
  logic [7:0]  scale;
  logic [3:0]  steps_log2;
  logic [10:0] center_x;
  logic [10:0] center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape      <= pcpg_pkg::SHP_ASTROID;
      scale      <= 8'd90;
      steps_log2 <= 4'd8;
      center_x   <= 11'd200;
      center_y   <= 11'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcpg_pkg::REG_SHAPE:    shape      <= cfg_data[2:0];
        pcpg_pkg::REG_SCALE:    scale      <= cfg_data[7:0];
        pcpg_pkg::REG_STEPS:    steps_log2 <= cfg_data[3:0];
        pcpg_pkg::REG_CENTER_X: center_x   <= cfg_data;
        pcpg_pkg::REG_CENTER_Y: center_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  pcpg_pkg::state_t state, state_next;

  logic        in_acc;
  logic        out_free;
  logic        pass;
  logic [4:0]  iter;
  logic        two_pass;

  // item registers
  logic [3:0]      s_eff;
  logic [IDXW-1:0] idx;
  logic            idx_zero;

  // cordic registers
  logic signed [33:0] cx, cy;
  logic signed [31:0] cz;
  logic [1:0]         quad;

  logic signed [16:0] c1, s1, c2, s2;
  logic signed [33:0] sq_x, sq_y;
  logic signed [50:0] cube_x, cube_y;
  logic [IDXW+27:0]   tprod;
  logic signed [19:0] coord_x, coord_y;
  logic signed [29:0] prod_x, prod_y;
  logic signed [PIXEL_BITS-1:0] last_x, last_y;

  assign in_stall = (state != pcpg_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign two_pass = (shape == pcpg_pkg::SHP_HUYGENS) ||
                    (shape == pcpg_pkg::SHP_HYPOCYCLOID) ||
                    (shape == pcpg_pkg::SHP_STARFISH);

  // input clamps
  logic [3:0]      s_in;
  logic [IDXW-1:0] idx_in, idx_lim;

  always_comb begin
    if (steps_log2 == 4'd0) begin
      s_in = 4'd1;
    end else if (steps_log2 > 4'(MAX_STEPS_LOG2)) begin
      s_in = 4'(MAX_STEPS_LOG2);
    end else begin
      s_in = steps_log2;
    end
    idx_lim = IDXW'(1) << s_in;
    idx_in  = (IDXW'(step_index) > idx_lim) ? idx_lim : IDXW'(step_index);
  end

  // phase of the pass about to start: multiple of the index, scaled to a turn
  logic [2:0]                  kmul;
  logic [KW-1:0]               kidx;
  logic [KW+ANGLE_BITS-1:0]    phase_w;
  logic [ANGLE_BITS-1:0]       phase;
  logic [3:0]                  s_ph;
  logic [IDXW-1:0]             idx_ph;
  logic                        pass_ph;

  always_comb begin
    s_ph    = (state == pcpg_pkg::ST_IDLE) ? s_in : s_eff;
    idx_ph  = (state == pcpg_pkg::ST_IDLE) ? idx_in : idx;
    pass_ph = (state != pcpg_pkg::ST_IDLE);
    unique case (shape)
      pcpg_pkg::SHP_CYCLOID:     kmul = 3'd2;
      pcpg_pkg::SHP_HUYGENS:     kmul = pass_ph ? 3'd6 : 3'd2;
      pcpg_pkg::SHP_HYPOCYCLOID: kmul = pass_ph ? 3'd2 : 3'd1;
      pcpg_pkg::SHP_STARFISH:    kmul = pass_ph ? 3'd2 : 3'd3;
      default:                   kmul = 3'd1;
    endcase
    kidx    = KW'(kmul) * KW'(idx_ph);
    phase_w = (KW+ANGLE_BITS)'(kidx) << (ANGLE_BITS - int'(s_ph));
    phase   = phase_w[ANGLE_BITS-1:0];
  end

  // cordic rounding and quadrant fold
  logic signed [33:0] xr_w, yr_w;
  logic signed [16:0] xs, ys, cos_q, sin_q;

  always_comb begin
    xr_w = (cx + 34'sd16384) >>> 15;
    yr_w = (cy + 34'sd16384) >>> 15;
    if (xr_w > 34'sd32767) begin
      xs = 17'sd32767;
    end else if (xr_w < -34'sd32768) begin
      xs = -17'sd32768;
    end else begin
      xs = xr_w[16:0];
    end
    if (yr_w > 34'sd32767) begin
      ys = 17'sd32767;
    end else if (yr_w < -34'sd32768) begin
      ys = -17'sd32768;
    end else begin
      ys = yr_w[16:0];
    end
    unique case (quad)
      2'd0: begin cos_q = xs;  sin_q = ys;  end
      2'd1: begin cos_q = -ys; sin_q = xs;  end
      2'd2: begin cos_q = -xs; sin_q = -ys; end
      default: begin cos_q = ys; sin_q = -xs; end
    endcase
  end

  // curve coordinates in q8.12
  logic signed [31:0] ex, ey, lin;
  logic [2:0]         rn;
  logic [47:0]        t15_w;
  logic signed [31:0] t15;
  logic signed [50:0] ax_w, ay_w;
  logic signed [31:0] rx_w, ry_w;
  logic signed [19:0] coord_x_next, coord_y_next;

  always_comb begin
    t15_w = (48'(tprod) + (48'd1 << (5'(s_eff) + 5'd8))) >> (5'(s_eff) + 5'd9);
    t15   = {12'd0, t15_w[19:0]};
    lin   = 32'(idx) << (4'd13 - s_eff);
    ax_w  = (cube_x + 51'sd2147483648) >>> 32;
    ay_w  = (cube_y + 51'sd2147483648) >>> 32;
    ex = 32'sd0;
    ey = 32'sd0;
    rn = 3'd3;
    unique case (shape)
      pcpg_pkg::SHP_CYCLOID: begin
        ex = 32'sd3 * (32'sd32768 - 32'(c1));
        ey = 32'sd3 * (t15 - 32'(s1));
        rn = 3'd4;
      end
      pcpg_pkg::SHP_HUYGENS: begin
        ex = 32'sd4 * (32'sd3 * 32'(c1) - 32'(c2));
        ey = 32'sd4 * (32'sd3 * 32'(s1) - 32'(s2));
      end
      pcpg_pkg::SHP_HYPOCYCLOID: begin
        ex = 32'sd3 * (32'sd2 * 32'(c1) + 32'(c2));
        ey = 32'sd3 * (32'sd2 * 32'(s1) - 32'(s2));
        rn = 3'd4;
      end
      pcpg_pkg::SHP_ELLIPSE: begin
        ex = 32'sd2 * 32'(c1);
        ey = 32'(s1);
      end
      pcpg_pkg::SHP_STARFISH: begin
        ex = 32'sd2 * 32'(c1) + 32'sd5 * 32'(c2);
        ey = 32'sd2 * 32'(s1) - 32'sd5 * 32'(s2);
      end
      default: begin
        ex = 32'(c1);
        ey = 32'(s1);
      end
    endcase
    rx_w = (ex + (32'sd1 <<< (rn - 3'd1))) >>> rn;
    ry_w = (ey + (32'sd1 <<< (rn - 3'd1))) >>> rn;
    unique case (shape)
      pcpg_pkg::SHP_ASTROID: begin
        coord_x_next = ax_w[19:0];
        coord_y_next = ay_w[19:0];
      end
      pcpg_pkg::SHP_LINE: begin
        coord_x_next = 20'sd4096 - lin[19:0];
        coord_y_next = 20'sd4096 - lin[19:0];
      end
      default: begin
        coord_x_next = rx_w[19:0];
        coord_y_next = ry_w[19:0];
      end
    endcase
  end

  // pixel: truncate toward zero, add center, saturate
  logic signed [29:0] trx, try_w;
  logic signed [31:0] vx, vy;
  logic signed [PIXEL_BITS-1:0] px_next, py_next;

  always_comb begin
    trx   = (prod_x >= 0) ? (prod_x >>> 12) : -((-prod_x) >>> 12);
    try_w = (prod_y >= 0) ? (prod_y >>> 12) : -((-prod_y) >>> 12);
    vx = 32'(trx) + $signed({21'd0, center_x});
    vy = 32'(try_w) + $signed({21'd0, center_y});
    if (vx > PIX_HI) begin
      px_next = PIX_HI[PIXEL_BITS-1:0];
    end else if (vx < PIX_LO) begin
      px_next = PIX_LO[PIXEL_BITS-1:0];
    end else begin
      px_next = vx[PIXEL_BITS-1:0];
    end
    if (vy > PIX_HI) begin
      py_next = PIX_HI[PIXEL_BITS-1:0];
    end else if (vy < PIX_LO) begin
      py_next = PIX_LO[PIXEL_BITS-1:0];
    end else begin
      py_next = vy[PIXEL_BITS-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcpg_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (shape == pcpg_pkg::SHP_LINE) ? pcpg_pkg::ST_SUM : pcpg_pkg::ST_ROT;
        end
      end
      pcpg_pkg::ST_ROT: begin
        if (iter == 5'(pcpg_pkg::CORDIC_ITERS - 1)) begin
          state_next = pcpg_pkg::ST_RND;
        end
      end
      pcpg_pkg::ST_RND: begin
        state_next = (two_pass && !pass) ? pcpg_pkg::ST_ROT : pcpg_pkg::ST_SQ;
      end
      pcpg_pkg::ST_SQ:    state_next = pcpg_pkg::ST_CUBE;
      pcpg_pkg::ST_CUBE:  state_next = pcpg_pkg::ST_SUM;
      pcpg_pkg::ST_SUM:   state_next = pcpg_pkg::ST_SCALE;
      pcpg_pkg::ST_SCALE: state_next = pcpg_pkg::ST_OUT;
      pcpg_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = pcpg_pkg::ST_IDLE;
        end
      end
      default: state_next = pcpg_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pass      <= 1'b0;
      iter      <= 5'd0;
      last_x    <= '0;
      last_y    <= '0;
    end else begin
      if (state == pcpg_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
        last_x    <= px_next;
        last_y    <= py_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        pass <= 1'b0;
        iter <= 5'd0;
      end else if (state == pcpg_pkg::ST_ROT) begin
        iter <= iter + 5'd1;
      end else if (state == pcpg_pkg::ST_RND) begin
        pass <= 1'b1;
        iter <= 5'd0;
      end
    end
  end

  // datapath
  logic signed [33:0] dx, dy;
  logic signed [31:0] at;
  logic signed [31:0] z_init;

  assign dx     = cy >>> iter;
  assign dy     = cx >>> iter;
  assign at     = pcpg_pkg::atan_turn(iter);
  assign z_init = {2'b00, phase[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (in_acc || state == pcpg_pkg::ST_RND) begin
      cx   <= pcpg_pkg::CORDIC_START;
      cy   <= '0;
      cz   <= z_init;
      quad <= phase[ANGLE_BITS-1:ANGLE_BITS-2];
    end else if (state == pcpg_pkg::ST_ROT) begin
      if (cz >= 0) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end
    if (in_acc) begin
      s_eff    <= s_in;
      idx      <= idx_in;
      idx_zero <= (idx_in == '0);
    end
    if (state == pcpg_pkg::ST_RND) begin
      if (pass) begin
        c2 <= cos_q;
        s2 <= sin_q;
      end else begin
        c1 <= cos_q;
        s1 <= sin_q;
      end
    end
    if (state == pcpg_pkg::ST_SQ) begin
      sq_x  <= s1 * s1;
      sq_y  <= c1 * c1;
      tprod <= (IDXW+28)'(idx) * (IDXW+28)'(pcpg_pkg::FOUR_PI_Q24);
    end
    if (state == pcpg_pkg::ST_CUBE) begin
      cube_x <= 51'(sq_x) * 51'(s1);
      cube_y <= 51'(sq_y) * 51'(c1);
    end
    if (state == pcpg_pkg::ST_SUM) begin
      coord_x <= coord_x_next;
      coord_y <= coord_y_next;
    end
    if (state == pcpg_pkg::ST_SCALE) begin
      prod_x <= 30'(coord_x) * $signed({22'd0, scale});
      prod_y <= 30'(coord_y) * $signed({22'd0, scale});
    end
    if (state == pcpg_pkg::ST_OUT && out_free) begin
      pixel_x <= px_next;
      pixel_y <= py_next;
      prev_x  <= idx_zero ? px_next : last_x;
      prev_y  <= idx_zero ? py_next : last_y;
    end
  end

endmodule

`default_nettype wire

/* rtl/pcpg_checker.sv */
// pcpg_assertions: port-level assertions for the curve point generator
// bound to parametric_curve_point_generator; no package use
`default_nettype none

module pcpg_assertions #(
  parameter int PIXEL_BITS = 15
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [PIXEL_BITS-1:0]   pixel_x,
  input wire logic [PIXEL_BITS-1:0]   pixel_y
);

  // a held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("output beat changed while stalled");

  // an accepted item keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accepting an item");

  // a new result only appears while an item is in progress
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without an item in progress");

endmodule

bind parametric_curve_point_generator pcpg_assertions #(.PIXEL_BITS(PIXEL_BITS)) u_pcpg_assertions (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pixel_x   (pixel_x),
  .pixel_y   (pixel_y)
);

`default_nettype wire
